// ===== design/lr_pkg.sv =====
// Shared types, constants and helpers for the line rasterizer.
package lr_pkg;

   localparam int COORD_BITS = 10;
   localparam int ERR_BITS   = COORD_BITS + 1;
   localparam int REQ_DATA_W = ((4 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   localparam logic [1:0] DIR_NONE  = 2'd0;
   localparam logic [1:0] DIR_PLUS  = 2'd1;
   localparam logic [1:0] DIR_MINUS = 2'd3;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [ERR_BITS-1:0]   err_type;

   typedef struct packed {
      logic        is_start;
      coord_type   col;
      coord_type   row;
      coord_type   abs_dx;
      coord_type   abs_dy;
      logic [1:0]  dir_col;
      logic [1:0]  dir_row;
      coord_type   major_len;
   } cmd_type;

   function automatic coord_type axis_move(input coord_type pos, input logic [1:0] dir);
      coord_type res;
      unique case (dir)
         DIR_PLUS:  res = pos + coord_type'(1);
         DIR_MINUS: res = pos - coord_type'(1);
         default:   res = pos;
      endcase
      return res;
   endfunction

endpackage

// ===== design/lr_front.sv =====
// Front end: decode an incoming item and precompute the line setup.
module lr_front
   import lr_pkg::*;
(
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   output logic                  push,
   output cmd_type               push_cmd,
   input  logic                  queue_ready
);

   coord_type sx, sy, ex, ey;
   coord_type adx, ady;
   logic [1:0] dcol, drow;

   assign sx = req_tdata[COORD_BITS-1:0];
   assign sy = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign ex = req_tdata[3*COORD_BITS-1:2*COORD_BITS];
   assign ey = req_tdata[4*COORD_BITS-1:3*COORD_BITS];

   always_comb begin
      if (ex > sx) begin
         dcol = DIR_PLUS;
         adx  = ex - sx;
      end else if (ex == sx) begin
         dcol = DIR_NONE;
         adx  = '0;
      end else begin
         dcol = DIR_MINUS;
         adx  = sx - ex;
      end
      if (ey > sy) begin
         drow = DIR_PLUS;
         ady  = ey - sy;
      end else if (ey == sy) begin
         drow = DIR_NONE;
         ady  = '0;
      end else begin
         drow = DIR_MINUS;
         ady  = sy - ey;
      end
   end

   always_comb begin
      push_cmd.is_start  = (req_tuser == CMD_START);
      push_cmd.col       = sx;
      push_cmd.row       = sy;
      push_cmd.abs_dx    = adx;
      push_cmd.abs_dy    = ady;
      push_cmd.dir_col   = dcol;
      push_cmd.dir_row   = drow;
      push_cmd.major_len = (adx > ady) ? adx : ady;
   end

   assign req_tready = queue_ready;
   assign push       = req_tvalid & queue_ready;

endmodule

// ===== design/lr_queue.sv =====
// Two-entry command queue between front and back.
module lr_queue
   import lr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    push_ready,
   input  logic    pop,
   output cmd_type pop_cmd,
   output logic    pop_valid
);

   cmd_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_cmd    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== design/lr_back.sv =====
// Back end: line stepping state and registered point output.
module lr_back
   import lr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_valid,
   input  cmd_type               cmd,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   logic      busy_ff, busy_in;
   coord_type col_ff, col_in;
   coord_type row_ff, row_in;
   coord_type adx_ff, adx_in;
   coord_type ady_ff, ady_in;
   logic [1:0] dcol_ff, dcol_in;
   logic [1:0] drow_ff, drow_in;
   coord_type major_ff, major_in;
   err_type   cerr_ff, cerr_in;
   err_type   rerr_ff, rerr_in;
   err_type   left_ff, left_in;

   logic      out_vld_ff, out_vld_in;
   coord_type out_x_ff, out_x_in;
   coord_type out_y_ff, out_y_in;
   logic      out_last_ff, out_last_in;

   logic      emit, is_final, col_hit, row_hit;
   err_type   col_sum, row_sum, major_w;

   assign pop      = cmd_valid & (~out_vld_ff | rsp_tready);
   assign emit     = pop & ~cmd.is_start & busy_ff;
   assign is_final = (left_ff <= err_type'(1));
   assign major_w  = {1'b0, major_ff};
   assign col_sum  = cerr_ff + {1'b0, adx_ff};
   assign row_sum  = rerr_ff + {1'b0, ady_ff};
   assign col_hit  = col_sum > major_w;
   assign row_hit  = row_sum > major_w;

   always_comb begin
      busy_in  = busy_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      adx_in   = adx_ff;
      ady_in   = ady_ff;
      dcol_in  = dcol_ff;
      drow_in  = drow_ff;
      major_in = major_ff;
      cerr_in  = cerr_ff;
      rerr_in  = rerr_ff;
      left_in  = left_ff;
      if (pop && cmd.is_start) begin
         busy_in  = 1'b1;
         col_in   = cmd.col;
         row_in   = cmd.row;
         adx_in   = cmd.abs_dx;
         ady_in   = cmd.abs_dy;
         dcol_in  = cmd.dir_col;
         drow_in  = cmd.dir_row;
         major_in = cmd.major_len;
         cerr_in  = '0;
         rerr_in  = '0;
         left_in  = {1'b0, cmd.major_len} + err_type'(2);
      end else if (emit) begin
         cerr_in = col_hit ? col_sum - major_w : col_sum;
         rerr_in = row_hit ? row_sum - major_w : row_sum;
         col_in  = col_hit ? axis_move(col_ff, dcol_ff) : col_ff;
         row_in  = row_hit ? axis_move(row_ff, drow_ff) : row_ff;
         if (is_final) begin
            left_in = '0;
            busy_in = 1'b0;
         end else begin
            left_in = left_ff - err_type'(1);
         end
      end
   end

   always_comb begin
      out_x_in    = out_x_ff;
      out_y_in    = out_y_ff;
      out_last_in = out_last_ff;
      out_vld_in  = out_vld_ff & ~rsp_tready;
      if (emit) begin
         out_vld_in  = 1'b1;
         out_x_in    = col_ff;
         out_y_in    = row_ff;
         out_last_in = is_final;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         col_ff     <= '0;
         row_ff     <= '0;
         adx_ff     <= '0;
         ady_ff     <= '0;
         dcol_ff    <= DIR_NONE;
         drow_ff    <= DIR_NONE;
         major_ff   <= '0;
         cerr_ff    <= '0;
         rerr_ff    <= '0;
         left_ff    <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         col_ff     <= col_in;
         row_ff     <= row_in;
         adx_ff     <= adx_in;
         ady_ff     <= ady_in;
         dcol_ff    <= dcol_in;
         drow_ff    <= drow_in;
         major_ff   <= major_in;
         cerr_ff    <= cerr_in;
         rerr_ff    <= rerr_in;
         left_ff    <= left_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = RSP_DATA_W'({out_y_ff, out_x_ff});
   assign rsp_tlast  = out_last_ff;

   a_idle_no_steps: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> left_ff == '0)
      else $error("steps left while idle");

   a_col_err_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cerr_ff <= major_w)
      else $error("column error above major length");

   a_row_err_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rerr_ff <= major_w)
      else $error("row error above major length");

   a_final_ends_line: assert property (@(posedge clock) disable iff (reset)
      (emit && is_final) |=> (!busy_ff && out_vld_ff && out_last_ff))
      else $error("final point did not end the line");

endmodule

// ===== design/line_rasterizer.sv =====
// Top level of the line rasterizer: front end, command queue and back end.
// A step item is written into the command queue, then popped by the back end into the registered point output.
// Throughput: one item per cycle while the queue has room; one point per step item while a line is active.
// A start item produces no point; a stalled rsp backs up through the two-entry queue.
// Reset is synchronous: the queue empties, the line goes idle and rsp_tvalid drops.
module line_rasterizer
   import lr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // start_x, start_y, end_x, end_y
   input  logic                  req_tuser,   // command
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // point_x, point_y, zero pad
   output logic                  rsp_tlast
);

   logic    push, push_ready, pop, pop_valid;
   cmd_type push_cmd, pop_cmd;

   lr_front u_front (
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .push        (push),
      .push_cmd    (push_cmd),
      .queue_ready (push_ready)
   );

   lr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_cmd    (pop_cmd),
      .pop_valid  (pop_valid)
   );

   lr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (pop_valid),
      .cmd        (pop_cmd),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== dv/line_rasterizer_tb.sv =====
// Self-checking line_rasterizer testbench: error-accumulator point model on random stream traffic.
`timescale 1ns / 100ps

module line_rasterizer_tb
   import lr_pkg::*;
();

   localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 200;

   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      last;
   } point_type;

   class point_scoreboard;
      point_type expected_points[$];
      bit        line_active;
      coord_type pen_col, pen_row, span_x, span_y, major_span;
      logic [1:0] step_col, step_row;
      err_type   err_col, err_row, points_left;
      int        failures;

      function new();
         line_active = 1'b0;
         pen_col     = '0;
         pen_row     = '0;
         span_x      = '0;
         span_y      = '0;
         major_span  = '0;
         step_col    = DIR_NONE;
         step_row    = DIR_NONE;
         err_col     = '0;
         err_row     = '0;
         points_left = '0;
         failures    = 0;
      endfunction

      function int pending();
         return expected_points.size();
      endfunction

      function void note_request(logic cmd, logic [REQ_DATA_W-1:0] data);
         coord_type sx, sy, ex, ey;
         point_type pt;
         sx = data[COORD_BITS-1:0];
         sy = data[2*COORD_BITS-1:COORD_BITS];
         ex = data[3*COORD_BITS-1:2*COORD_BITS];
         ey = data[4*COORD_BITS-1:3*COORD_BITS];
         if (cmd == CMD_START) begin
            if (ex > sx) begin
               step_col = DIR_PLUS;
               span_x   = ex - sx;
            end else if (ex == sx) begin
               step_col = DIR_NONE;
               span_x   = '0;
            end else begin
               step_col = DIR_MINUS;
               span_x   = sx - ex;
            end
            if (ey > sy) begin
               step_row = DIR_PLUS;
               span_y   = ey - sy;
            end else if (ey == sy) begin
               step_row = DIR_NONE;
               span_y   = '0;
            end else begin
               step_row = DIR_MINUS;
               span_y   = sy - ey;
            end
            major_span  = (span_x > span_y) ? span_x : span_y;
            pen_col     = sx;
            pen_row     = sy;
            err_col     = '0;
            err_row     = '0;
            points_left = err_type'(major_span) + err_type'(2);
            line_active = 1'b1;
            return;
         end
         if (!line_active) return;
         pt.x    = pen_col;
         pt.y    = pen_row;
         pt.last = (points_left <= 1);
         expected_points.push_back(pt);
         err_col = err_col + span_x;
         err_row = err_row + span_y;
         if (err_col > major_span) begin
            err_col = err_col - major_span;
            case (step_col)
               DIR_PLUS:  pen_col = pen_col + 1'b1;
               DIR_MINUS: pen_col = pen_col - 1'b1;
               default:   ;
            endcase
         end
         if (err_row > major_span) begin
            err_row = err_row - major_span;
            case (step_row)
               DIR_PLUS:  pen_row = pen_row + 1'b1;
               DIR_MINUS: pen_row = pen_row - 1'b1;
               default:   ;
            endcase
         end
         if (points_left <= 1) begin
            points_left = '0;
            line_active = 1'b0;
         end else begin
            points_left = points_left - 1'b1;
         end
      endfunction

      function void check_point(logic [RSP_DATA_W-1:0] data, logic tlast);
         point_type want;
         coord_type got_x, got_y;
         got_x = data[COORD_BITS-1:0];
         got_y = data[2*COORD_BITS-1:COORD_BITS];
         if (expected_points.size() == 0) begin
            $error("unexpected point: point_x %0d point_y %0d last %0b", got_x, got_y, tlast);
            failures++;
            return;
         end
         want = expected_points.pop_front();
         if (got_x !== want.x) begin
            $error("point_x mismatch: expected %0d actual %0d", want.x, got_x);
            failures++;
         end
         if (got_y !== want.y) begin
            $error("point_y mismatch: expected %0d actual %0d", want.y, got_y);
            failures++;
         end
         if (tlast !== want.last) begin
            $error("last mismatch: expected %0b actual %0b", want.last, tlast);
            failures++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // start_x, start_y, end_x, end_y
   logic                  req_tuser  = 1'b0; // command
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // point_x, point_y, zero pad
   logic                  rsp_tlast;

   point_scoreboard sb = new();
   int  sent_items  = 0;
   int  quiet_cycles = 0;
   bit  burst       = 1'b0;
   bit  hold_rsp    = 1'b0;

   line_rasterizer DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_request(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_point(rsp_tdata, rsp_tlast);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("line_rasterizer test failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      int pick;
      int run;
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
               rsp_tready <= 1'b1;
               run = $urandom_range(1, 20);
            end else if (pick < 9) begin
               rsp_tready <= 1'b0;
               run = $urandom_range(1, 3);
            end else begin
               rsp_tready <= 1'b0;
               run = $urandom_range(10, 40);
            end
            repeat (run) @(posedge clock);
         end
      end
   end

   function automatic int pick_gap();
      int pick;
      if (burst) return 0;
      pick = $urandom_range(0, 19);
      if (pick < 12) return 0;
      if (pick < 18) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [REQ_DATA_W-1:0] pack_ends(coord_type sx, coord_type sy,
                                                        coord_type ex, coord_type ey);
      logic [REQ_DATA_W-1:0] word;
      word = '0;
      word[4*COORD_BITS-1:0] = {ey, ex, sy, sx};
      return word;
   endfunction

   function automatic int clamp_coord(int v);
      if (v < 0) return 0;
      if (v > COORD_MAX) return COORD_MAX;
      return v;
   endfunction

   task automatic send_item(input logic cmd, input logic [REQ_DATA_W-1:0] data);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_items++;
   endtask

   task automatic draw_line(input int sx, input int sy, input int ex, input int ey,
                            input int steps);
      logic [REQ_DATA_W-1:0] noise;
      send_item(CMD_START, pack_ends(coord_type'(sx), coord_type'(sy),
                                     coord_type'(ex), coord_type'(ey)));
      repeat (steps) begin
         noise = REQ_DATA_W'({$urandom(), $urandom()});
         send_item(CMD_STEP, noise);
      end
   endtask

   initial begin
      int sx, sy, ex, ey, span, kind, steps;
      bit hold_done, pause_done;
      hold_done  = 1'b0;
      pause_done = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_item(CMD_STEP, '1);
      draw_line(0, 0, 0, 0, 3);
      draw_line(COORD_MAX, COORD_MAX, COORD_MAX - 3, COORD_MAX, 5);
      draw_line(0, COORD_MAX, 2, COORD_MAX - 3, 5);
      draw_line(0, 0, COORD_MAX, COORD_MAX, 3);
      draw_line(COORD_MAX, 0, COORD_MAX - 1, 1, 3);

      while (sent_items < 425) begin
         burst = ($urandom_range(0, 4) == 0);
         if (!hold_done && sent_items >= 100) begin
            hold_rsp  = 1'b1;
            hold_done = 1'b1;
         end
         if (!pause_done && sent_items >= 260) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (sb.pending() != 0) @(posedge clock);
            pause_done = 1'b1;
         end
         sx = $urandom_range(0, COORD_MAX);
         sy = $urandom_range(0, COORD_MAX);
         if ($urandom_range(0, 19) == 0) begin
            ex = clamp_coord(sx + $urandom_range(0, 200) - 100);
            ey = clamp_coord(sy + $urandom_range(0, 200) - 100);
         end else begin
            ex = clamp_coord(sx + $urandom_range(0, 24) - 12);
            ey = clamp_coord(sy + $urandom_range(0, 24) - 12);
         end
         span = (ex > sx) ? ex - sx : sx - ex;
         if (((ey > sy) ? ey - sy : sy - ey) > span) span = (ey > sy) ? ey - sy : sy - ey;
         kind  = $urandom_range(0, 9);
         steps = span + 2;
         if (kind >= 7 && kind < 9) steps = $urandom_range(0, span + 1);
         else if (kind == 9) steps = span + 2 + $urandom_range(1, 3);
         if (span > 64 && $urandom_range(0, 3) != 0) steps = $urandom_range(1, 40);
         draw_line(sx, sy, ex, ey, steps);
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.pending() != 0) begin
         $error("%0d expected points never arrived", sb.pending());
      end
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("line_rasterizer test passed");
      end else begin
         $display("line_rasterizer test failed");
      end
      $finish;
   end

endmodule
